@@ rtl/dpa_pkg.sv @@
`default_nettype none

package dpa_pkg;

    localparam int DEF_TABLE_ENTRIES = 64;

    localparam int IDX_IN_W   = 6;
    localparam int COUNT_W    = 32;
    localparam int TIME_W     = 32;
    localparam int CFG_W      = 16;
    localparam int DEMAND_W   = 38;
    localparam int PRODUCT_W  = 44;
    localparam int HOUR_W     = 12;

    localparam logic [CFG_W-1:0]   CFG_RESET     = 16'd60;
    localparam logic [HOUR_W-1:0]  SECS_PER_HOUR = 12'd3600;
    localparam logic [COUNT_W-1:0] ROLL_LOW      = 32'h0000_FFFF;
    localparam logic [COUNT_W-1:0] ROLL_HIGH     = 32'hFFFF_FFFF;

    // one quotient bit per step
    localparam int DIV_STEPS = PRODUCT_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    typedef enum logic [1:0] {
        OUT_STORED    = 2'd0,
        OUT_TOO_SHORT = 2'd1,
        OUT_DEMAND    = 2'd2
    } t_outcome;

    typedef struct packed {
        logic [IDX_IN_W-1:0] point_index;
        logic [COUNT_W-1:0]  pulse_count;
        logic [TIME_W-1:0]   sample_time;
    } t_request;

    typedef struct packed {
        t_outcome            outcome;
        logic [DEMAND_W-1:0] demand_value;
    } t_result;

    typedef struct packed {
        logic                valid;
        logic [COUNT_W-1:0]  count;
        logic [TIME_W-1:0]   stamp;
    } t_entry;

    typedef struct packed {
        logic     clr;
        logic     load;
        logic     rd;
        logic     calc;
        logic     mul;
        logic     div;
        logic     store;
        logic     emit;
        t_outcome outcome;
    } t_cmd;

    typedef struct packed {
        logic hit;
        logic short_gap;
        logic clr_done;
    } t_status;

endpackage

`default_nettype wire

@@ rtl/dpa_ctrl.sv @@
`default_nettype none

module dpa_ctrl (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   start,
    output logic                  busy,
    input  wire dpa_pkg::t_status i_status,
    output dpa_pkg::t_cmd         o_cmd
);
    import dpa_pkg::*;

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_READ  = 7'b0000100,
        S_CHECK = 7'b0001000,
        S_MUL   = 7'b0010000,
        S_DIV   = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    t_state               r_state, n_state;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        o_cmd.outcome = OUT_STORED;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_status.clr_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_READ;
                end
            end
            S_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = S_CHECK;
            end
            S_CHECK: begin
                if (!i_status.hit) begin
                    o_cmd.store   = 1'b1;
                    o_cmd.emit    = 1'b1;
                    o_cmd.outcome = OUT_STORED;
                    n_state       = S_IDLE;
                end else if (i_status.short_gap) begin
                    o_cmd.emit    = 1'b1;
                    o_cmd.outcome = OUT_TOO_SHORT;
                    n_state       = S_IDLE;
                end else begin
                    o_cmd.calc  = 1'b1;
                    o_cmd.store = 1'b1;
                    n_state     = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_cnt     = '0;
                n_state   = S_DIV;
            end
            S_DIV: begin
                o_cmd.div = 1'b1;
                n_cnt     = r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) n_state = S_DONE;
            end
            S_DONE: begin
                o_cmd.emit    = 1'b1;
                o_cmd.outcome = OUT_DEMAND;
                n_state       = S_IDLE;
            end
            default: n_state = S_CLEAR;
        endcase
    end

    assign busy = (r_state != S_IDLE);

endmodule

`default_nettype wire

@@ rtl/dpa_datapath.sv @@
`default_nettype none

module dpa_datapath #(
    parameter int TABLE_ENTRIES = dpa_pkg::DEF_TABLE_ENTRIES
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire dpa_pkg::t_request      i_request,
    input  wire                         i_cfg_we,
    input  wire [dpa_pkg::CFG_W-1:0]    i_cfg_wdata,
    input  wire dpa_pkg::t_cmd          i_cmd,
    output dpa_pkg::t_status            o_status,
    output logic                        o_strobe,
    output dpa_pkg::t_result            o_result
);
    import dpa_pkg::*;

    localparam int IDX_W   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int MOD_LIM = (TABLE_ENTRIES > 64) ? 64 : TABLE_ENTRIES;
    localparam logic [IDX_IN_W:0] MOD_N = (IDX_IN_W + 1)'(MOD_LIM);

    logic [CFG_W-1:0]     r_min_gap;
    logic [IDX_W-1:0]     r_clr_addr;
    logic [IDX_W-1:0]     r_slot;
    logic [COUNT_W-1:0]   r_count;
    logic [TIME_W-1:0]    r_time;
    t_entry               r_mem [TABLE_ENTRIES];
    t_entry               r_rd;
    logic [COUNT_W-1:0]   r_delta;
    logic [TIME_W-1:0]    r_elapsed;
    logic [PRODUCT_W-1:0] r_quot;
    logic [TIME_W-1:0]    r_rem;
    logic                 r_strobe;
    t_result              r_result;

    logic [IDX_IN_W:0]    w_mod;
    logic [IDX_W-1:0]     w_slot;
    logic [CFG_W-1:0]     w_gap;
    logic                 w_short;
    logic [COUNT_W-1:0]   w_top;
    logic [COUNT_W-1:0]   w_delta;
    logic [PRODUCT_W-1:0] w_prod;
    logic [TIME_W:0]      w_trial;
    logic                 w_ge;
    logic [DEMAND_W-1:0]  w_sat;
    logic                 w_we;
    logic [IDX_W-1:0]     w_waddr;
    t_entry               w_wdata;

    // index reduced modulo the table size, restoring style on six bits
    always_comb begin
        w_mod = '0;
        for (int i = IDX_IN_W - 1; i >= 0; i--) begin
            w_mod = {w_mod[IDX_IN_W-1:0], i_request.point_index[i]};
            if (w_mod >= MOD_N) w_mod = w_mod - MOD_N;
        end
        w_slot = IDX_W'(w_mod);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_gap  <= CFG_RESET;
            r_clr_addr <= '0;
            r_strobe   <= 1'b0;
        end else begin
            if (i_cfg_we) r_min_gap <= i_cfg_wdata;
            if (i_cmd.clr) r_clr_addr <= r_clr_addr + 1'b1;
            r_strobe <= i_cmd.emit;
        end
    end

    // request capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_slot  <= w_slot;
            r_count <= i_request.pulse_count;
            r_time  <= i_request.sample_time;
        end
    end

    // sample table: one write port shared by the clearing pass and updates
    assign w_we    = i_cmd.clr | i_cmd.store;
    assign w_waddr = i_cmd.clr ? r_clr_addr : r_slot;
    always_comb begin
        w_wdata       = '0;
        w_wdata.valid = ~i_cmd.clr;
        w_wdata.count = i_cmd.clr ? '0 : r_count;
        w_wdata.stamp = i_cmd.clr ? '0 : r_time;
    end

    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_waddr] <= w_wdata;
        if (i_cmd.rd) r_rd <= r_mem[r_slot];
    end

    // zero gap behaves as one second
    assign w_gap   = (r_min_gap == '0) ? CFG_W'(1) : r_min_gap;
    assign w_short = ({1'b0, r_rd.stamp} + (TIME_W + 1)'(w_gap)) > {1'b0, r_time};

    assign w_top   = (r_rd.count > ROLL_LOW) ? ROLL_HIGH : ROLL_LOW;
    assign w_delta = (r_rd.count <= r_count) ? (r_count - r_rd.count)
                                             : (w_top - r_rd.count) + r_count;

    assign w_prod  = r_delta * SECS_PER_HOUR;

    assign w_trial = {r_rem, r_quot[PRODUCT_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_elapsed});

    always_ff @(posedge i_clk) begin
        if (i_cmd.calc) begin
            r_delta   <= w_delta;
            r_elapsed <= r_time - r_rd.stamp;
        end
        if (i_cmd.mul) begin
            r_quot <= w_prod;
            r_rem  <= '0;
        end else if (i_cmd.div) begin
            r_quot <= {r_quot[PRODUCT_W-2:0], w_ge};
            r_rem  <= w_ge ? TIME_W'(w_trial - {1'b0, r_elapsed}) : TIME_W'(w_trial);
        end
    end

    assign w_sat = (|r_quot[PRODUCT_W-1:DEMAND_W]) ? '1 : r_quot[DEMAND_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_result.outcome      <= i_cmd.outcome;
            r_result.demand_value <= (i_cmd.outcome == OUT_DEMAND) ? w_sat : '0;
        end
    end

    assign o_status.hit       = r_rd.valid;
    assign o_status.short_gap = w_short;
    assign o_status.clr_done  = (r_clr_addr == IDX_W'(TABLE_ENTRIES - 1));
    assign o_strobe           = r_strobe;
    assign o_result           = r_result;

    a_zero_unless_demand: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.outcome != OUT_DEMAND) |-> (o_result.demand_value == '0))
        else $error("demand value not zero for a non-demand outcome");

    a_calc_needs_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.calc |-> (r_rd.valid && !w_short))
        else $error("demand computed for a missing or too recent entry");

    a_elapsed_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.calc |=> (r_elapsed != '0))
        else $error("elapsed time is zero");

    a_rem_below_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div |=> (r_rem < r_elapsed))
        else $error("division remainder not below divisor");

endmodule

`default_nettype wire

@@ rtl/demand_from_pulse_accumulator_unit.sv @@
`default_nettype none

// Pulse-per-hour demand from successive meter accumulator readings.
// Request channel: i_request (point index, pulse count, timestamp) is taken
// when start is high and busy is low. Each request gives exactly one result
// on o_result, marked by o_strobe for a single cycle; there is no back-pressure.
// Configuration: i_cfg_we writes i_cfg_wdata to the minimum sample interval
// (reset value 60 s); write only while busy is low.
// Sequence: for a first sample or a too-short interval the result follows the
// table read and check. A demand computation then runs a multiply step and
// the 44-step restoring divider (one quotient bit per cycle).
// Throughput: one request at a time; busy stays high until the computation
// ends, and a new request may be taken while the last result is on the outputs.
// Reset: a clearing pass writes every table entry, one per cycle, and busy
// stays high until the pass ends. Configuration writes are taken
// during that pass.
module demand_from_pulse_accumulator_unit #(
    parameter int TABLE_ENTRIES = dpa_pkg::DEF_TABLE_ENTRIES
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         start,
    output logic                        busy,
    input  wire dpa_pkg::t_request      i_request,
    input  wire                         i_cfg_we,
    input  wire [dpa_pkg::CFG_W-1:0]    i_cfg_wdata,
    output logic                        o_strobe,
    output dpa_pkg::t_result            o_result
);
    import dpa_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    dpa_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    dpa_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_request   (i_request),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_strobe    (o_strobe),
        .o_result    (o_result)
    );

endmodule

`default_nettype wire

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    import dpa_pkg::*;

    localparam int ENTRIES      = DEF_TABLE_ENTRIES;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int PHASE_REQS   = 260;
    localparam int DRAIN_CYCLES = 60;
    localparam logic [DEMAND_W-1:0] DEMAND_SAT = '1;

    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             start       = 1'b0;
    logic             busy;
    t_request         i_request   = '0;
    logic             i_cfg_we    = 1'b0;
    logic [CFG_W-1:0] i_cfg_wdata = '0;
    logic             o_strobe;
    t_result          o_result;

    demand_from_pulse_accumulator_unit #(
        .TABLE_ENTRIES(ENTRIES)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_request  (i_request),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .o_strobe   (o_strobe),
        .o_result   (o_result)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // predictor copy of the table and the interval register
    logic [COUNT_W-1:0] held_count [ENTRIES];
    logic [TIME_W-1:0]  held_stamp [ENTRIES];
    logic               held_valid [ENTRIES];
    logic [CFG_W-1:0]   interval_cfg = CFG_RESET;

    // stimulus-side guess of each point's latest reading
    logic [COUNT_W-1:0] gen_count [ENTRIES];
    logic [TIME_W-1:0]  gen_stamp [ENTRIES];

    t_request req_pending_q [$];
    t_result  demand_exp_q [$];

    int gap_left  = 0;
    bit quiet     = 1'b0;
    int n_fail    = 0;
    int n_stored  = 0;
    int n_short   = 0;
    int n_demand  = 0;
    int n_sat     = 0;
    int n_cfg     = 0;
    int unsigned cycle_count = 0;

    function automatic t_result demand_predict(t_request req);
        int unsigned slot;
        logic [63:0] gap, elapsed, delta, top, demand;
        t_result     res;
        slot = req.point_index % ENTRIES;
        gap  = (interval_cfg == '0) ? 64'd1 : 64'(interval_cfg);
        res.demand_value = '0;
        if (!held_valid[slot]) begin
            held_valid[slot] = 1'b1;
            held_count[slot] = req.pulse_count;
            held_stamp[slot] = req.sample_time;
            res.outcome = OUT_STORED;
        end else if (64'(held_stamp[slot]) + gap > 64'(req.sample_time)) begin
            // also covers a timestamp behind the stored one
            res.outcome = OUT_TOO_SHORT;
        end else begin
            elapsed = 64'(req.sample_time) - 64'(held_stamp[slot]);
            if (req.pulse_count >= held_count[slot]) begin
                delta = 64'(req.pulse_count) - 64'(held_count[slot]);
            end else begin
                top = (held_count[slot] > ROLL_LOW) ? 64'(ROLL_HIGH) : 64'(ROLL_LOW);
                delta = (top - 64'(held_count[slot])) + 64'(req.pulse_count);
            end
            demand = (delta * 64'(SECS_PER_HOUR)) / elapsed;
            if (demand > 64'(DEMAND_SAT))
                demand = 64'(DEMAND_SAT);
            held_count[slot] = req.pulse_count;
            held_stamp[slot] = req.sample_time;
            res.outcome      = OUT_DEMAND;
            res.demand_value = demand[DEMAND_W-1:0];
        end
        return res;
    endfunction

    task automatic queue_request(input logic [IDX_IN_W-1:0] idx,
                                 input logic [COUNT_W-1:0] count,
                                 input logic [TIME_W-1:0] stamp);
        t_request req;
        req.point_index = idx;
        req.pulse_count = count;
        req.sample_time = stamp;
        gen_count[idx]  = count;
        gen_stamp[idx]  = stamp;
        req_pending_q.insert(req_pending_q.size(), req);
    endtask

    // mostly plausible meter sequences, with short intervals, rollovers and noise
    task automatic queue_random_request();
        int unsigned        slot, pick, roll;
        logic [31:0]        gap, dt;
        logic [COUNT_W-1:0] count;
        logic [TIME_W-1:0]  stamp;
        gap  = (interval_cfg == '0) ? 32'd1 : 32'(interval_cfg);
        slot = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 7) : $urandom_range(0, ENTRIES-1);
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            count = $urandom;
            stamp = $urandom;
        end else begin
            roll = $urandom_range(0, 9);
            if (pick < 20)
                dt = $urandom_range(0, gap - 1);
            else if (roll < 5)
                dt = gap + $urandom_range(0, 20);
            else if (roll < 8)
                dt = gap + $urandom_range(0, 5000);
            else if (roll == 8)
                dt = $urandom;
            else
                dt = gap;
            stamp = gen_stamp[slot] + dt;
            roll = $urandom_range(0, 9);
            if (roll < 6)
                count = gen_count[slot] + $urandom_range(0, 2000);
            else if (roll == 6)
                count = gen_count[slot];
            else if (roll == 7)
                count = gen_count[slot] + $urandom;
            else if (roll == 8)
                count = $urandom_range(0, 300);
            else
                count = gen_count[slot] + $urandom_range(32'hFFFF_0000, 32'hFFFF_FFFF);
        end
        queue_request(slot[IDX_IN_W-1:0], count, stamp);
    endtask

    task automatic wait_drained();
        while (req_pending_q.size() != 0 || start || demand_exp_q.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_interval(input logic [CFG_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we     <= 1'b0;
        interval_cfg  = value;
        n_cfg++;
    endtask

    task automatic queue_random_phase();
        for (int i = 0; i < PHASE_REQS; i++)
            queue_random_request();
    endtask

    always @(posedge i_clk) begin : driver
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy)
                demand_exp_q.insert(demand_exp_q.size(), demand_predict(i_request));
            // a request not yet taken stays on the port
            if (!(start && busy)) begin
                if (gap_left > 0) begin
                    gap_left--;
                    start <= 1'b0;
                end else if (req_pending_q.size() != 0 && !quiet
                             && $urandom_range(0, 4) == 0) begin
                    gap_left = $urandom_range(0, 2);
                    start <= 1'b0;
                end else if (req_pending_q.size() != 0) begin
                    i_request <= req_pending_q.pop_front();
                    start     <= 1'b1;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : monitor
        t_result want;
        if (i_rst_n && o_strobe) begin
            if (demand_exp_q.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual outcome %0d demand %0d",
                         $time, o_result.outcome, o_result.demand_value);
                n_fail++;
            end else begin
                want = demand_exp_q.pop_front();
                if (o_result.outcome !== want.outcome) begin
                    $display("%0t: outcome mismatch: expected %0d, actual %0d",
                             $time, want.outcome, o_result.outcome);
                    n_fail++;
                end
                if (o_result.demand_value !== want.demand_value) begin
                    $display("%0t: demand mismatch: expected %0d, actual %0d",
                             $time, want.demand_value, o_result.demand_value);
                    n_fail++;
                end
                case (want.outcome)
                    OUT_STORED:    n_stored++;
                    OUT_TOO_SHORT: n_short++;
                    default: begin
                        n_demand++;
                        if (want.demand_value == DEMAND_SAT)
                            n_sat++;
                    end
                endcase
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb_top failed");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < ENTRIES; i++) begin
            held_count[i] = '0;
            held_stamp[i] = '0;
            held_valid[i] = 1'b0;
            gen_count[i]  = '0;
            gen_stamp[i]  = '0;
        end
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset interval of 60 s
        queue_request(6'd0, 32'd0, 32'd0);
        queue_request(6'd0, 32'd100, 32'd59);
        queue_request(6'd0, 32'd100, 32'd60);
        queue_request(6'd0, 32'd50, 32'd200);            // rollover, low max
        queue_request(6'd0, 32'd50, 32'd150);            // timestamp behind
        queue_request(6'd63, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_request(6'd63, 32'd0, 32'hFFFF_FFFF);
        queue_request(6'd1, 32'h0001_0000, 32'd1000);
        queue_request(6'd1, 32'd5, 32'd1060);            // rollover, high max
        queue_request(6'd2, 32'h0000_FFFF, 32'd0);
        queue_request(6'd2, 32'd3, 32'd60);              // rollover from exactly 0xFFFF
        queue_request(6'd3, 32'd0, 32'hFFFF_0000);
        queue_request(6'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_request(6'd4, 32'd10, 32'hFFFF_FFC3);
        queue_request(6'd4, 32'd20, 32'hFFFF_FFFF);
        queue_request(6'd4, 32'd30, 32'd10);             // wrapped clock
        queue_request(6'd5, 32'd7, 32'd100);
        queue_request(6'd5, 32'd7, 32'd160);
        queue_random_phase();
        wait_drained();

        // zero register behaves as a one-second interval
        write_interval('0);
        queue_request(6'd6, 32'd0, 32'd0);
        queue_request(6'd6, 32'hFFFF_FFFF, 32'd1);       // saturates
        queue_request(6'd6, 32'hFFFF_FFFF, 32'd1);
        queue_request(6'd6, 32'hFFFF_FFFF, 32'd2);
        queue_random_phase();
        wait_drained();

        write_interval(16'd1);
        queue_random_phase();
        wait_drained();

        write_interval(16'hFFFF);
        queue_request(6'd7, 32'd0, 32'd0);
        queue_request(6'd7, 32'd1, 32'd65534);
        queue_request(6'd7, 32'd1, 32'd65535);
        queue_random_phase();
        wait_drained();

        write_interval(16'($urandom_range(2, 65534)));
        queue_random_phase();
        wait_drained();

        write_interval(16'($urandom_range(2, 600)));
        queue_random_phase();
        wait_drained();

        quiet = 1'b1;
        write_interval(16'($urandom_range(1, 120)));
        queue_random_phase();
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (demand_exp_q.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, demand_exp_q.size());
            n_fail++;
        end
        $display("Checked %0d requests: %0d stored, %0d too short, %0d demand (%0d saturated)",
                 n_stored + n_short + n_demand, n_stored, n_short, n_demand, n_sat);
        $display("Interval register written %0d times, %0d mismatches", n_cfg, n_fail);
        if (n_fail == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule

@@ demand_from_pulse_accumulator_unit.f @@
rtl/dpa_pkg.sv
rtl/dpa_ctrl.sv
rtl/dpa_datapath.sv
rtl/demand_from_pulse_accumulator_unit.sv
bench/tb_top.sv
